FILE: sv/cflts_pkg.sv
// Shared types and constants for the CFL timestep reduction unit.
// No dependencies; used by the top level.
`timescale 1ns / 1ps
`default_nettype none
package cflts_pkg;

   localparam int DATA_WIDTH = 32;               // speed word width, Q16.16
   localparam int MAX_POWER  = 8;                // largest p-norm exponent
   localparam int MIN_POWER  = 2;
   localparam int Q30_FRAC   = 30;               // ratio format Q2.30
   localparam int AXIS_FRAC  = 16;               // Q16.16 spacing product shift
   localparam int COEFF_W    = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int POW_W      = 4;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INV_X   = 3'd0,
      CSR_INV_Y   = 3'd1,
      CSR_INV_Z   = 3'd2,
      CSR_MODE    = 3'd3,
      CSR_POWER   = 3'd4,
      CSR_COEFF   = 3'd5
   } csr_index_type;

   // combine_mode bits
   localparam int MODE_BIT_SUM  = 0;
   localparam int MODE_BIT_NORM = 1;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_AXIS   = 11'b000_0000_0010,
      ST_COMB   = 11'b000_0000_0100,
      ST_RINIT  = 11'b000_0000_1000,
      ST_RATIO  = 11'b000_0001_0000,
      ST_POW    = 11'b000_0010_0000,
      ST_SCALE  = 11'b000_0100_0000,
      ST_UPDATE = 11'b000_1000_0000,
      ST_FINISH = 11'b001_0000_0000,
      ST_DIV    = 11'b010_0000_0000,
      ST_OUT    = 11'b100_0000_0000
   } state_type;

endpackage
`default_nettype wire

FILE: sv/cfl_timestep_reduction_unit.sv
// CFL timestep reduction: per-cell axis speeds, axis combine, sweep maximum, final quotient.
// Depends on cflts_pkg (states, register indexes, widths).
`timescale 1ns / 1ps
// Per cell: axis, combine and update steps. p-norm mode adds ratio, power, root and
// scale steps on the shared multiplier and the one-bit-per-cycle divider; a last cell
// adds a final divide (skipped when the maximum is zero) and an output step, plus any
// wait for the result register.
// Throughput: one cell at a time; req_tready is high only in idle.
// Reset (synchronous, active high): state to idle, configuration to its defaults,
// running maximum 0, no result pending.
`default_nettype none
module cfl_timestep_reduction_unit (
   input  wire logic          clock,
   input  wire logic          reset,
   // cell stream
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [127:0]  req_tdata,   // vel_x, vel_y, vel_z, signal_speed (low to high)
   input  wire logic          req_tlast,   // last_cell
   // result stream
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [31:0]        rsp_tdata,   // time_step
   output logic [0:0]         rsp_tuser,   // zero_speed_error
   // register writes
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [2:0]    csr_index,
   input  wire logic [31:0]   csr_data
);

   localparam int DW = cflts_pkg::DATA_WIDTH;

   // configuration
   logic [31:0] inv_x_ff, inv_y_ff, inv_z_ff;
   logic [1:0]  mode_ff;
   logic [3:0]  power_ff;
   logic [16:0] coeff_ff;

   // sequencer
   cflts_pkg::state_type state_ff, state_in;
   logic [1:0]  cnt_ff, cnt_in;             // axis index
   logic [DW:0] s_ff [3];                   // |v| + a per axis, exact
   logic [DW:0] s_in [3];
   logic [DW-1:0] x_ff [3];                 // axis speeds
   logic [DW-1:0] x_in [3];
   logic        last_ff, last_in;
   logic [DW-1:0] m_ff, m_in;               // largest axis speed
   logic [DW-1:0] cell_ff, cell_in;
   logic [DW-1:0] runmax_ff, runmax_in;

   // power / root loop
   logic [32:0] acc_ff, acc_in;
   logic [30:0] base_ff, base_in;
   logic        ovf_ff, ovf_in;
   logic [3:0]  pcnt_ff, pcnt_in;
   logic [34:0] sum_ff, sum_in;
   logic [30:0] u_ff, u_in;
   logic [4:0]  bit_ff, bit_in;
   logic        root_ff, root_in;

   // shared restoring divider
   logic [31:0] rem_ff, rem_in;
   logic [32:0] dvd_ff, dvd_in;
   logic [32:0] quo_ff, quo_in;
   logic [5:0]  dcnt_ff, dcnt_in;

   // result
   logic [31:0] res_time_ff, res_time_in;
   logic        res_err_ff, res_err_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0] rsp_time_ff, rsp_time_in;
   logic        rsp_err_ff, rsp_err_in;

   // shared multiplier
   logic [32:0] mul_a;
   logic [31:0] mul_b;
   logic [64:0] mul_prod;

   logic [31:0] inv_sel;
   logic [3:0]  pwr;
   logic [31:0] mag [3];
   logic [32:0] trial;
   logic [31:0] dsr;
   logic        ge;
   logic [31:0] rem_step;
   logic [34:0] pow_next;
   logic        ovf_next;
   logic [34:0] pow_val;
   logic [31:0] x_max;
   logic [32:0] add01;
   logic [31:0] sat01;
   logic [32:0] add012;
   logic [30:0] u_next;
   logic        out_free;

   assign req_tready = (state_ff == cflts_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_time_ff;
   assign rsp_tuser  = rsp_err_ff;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // clamp p into 2..MAX_POWER
   always_comb begin
      if (power_ff < 4'(cflts_pkg::MIN_POWER)) begin
         pwr = 4'(cflts_pkg::MIN_POWER);
      end else if (power_ff > 4'(cflts_pkg::MAX_POWER)) begin
         pwr = 4'(cflts_pkg::MAX_POWER);
      end else begin
         pwr = power_ff;
      end
   end

   always_comb begin
      case (cnt_ff)
         2'd0:    inv_sel = inv_x_ff;
         2'd1:    inv_sel = inv_y_ff;
         default: inv_sel = inv_z_ff;
      endcase
   end

   // two's-complement magnitude; the most negative code maps to 2^31
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag[i] = req_tdata[32*i+31] ? (~req_tdata[32*i +: 32] + 32'd1)
                                     : req_tdata[32*i +: 32];
      end
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         cflts_pkg::ST_AXIS: begin
            mul_a = s_ff[cnt_ff];
            mul_b = inv_sel;
         end
         cflts_pkg::ST_POW: begin
            mul_a = acc_ff;
            mul_b = {1'b0, base_ff};
         end
         cflts_pkg::ST_SCALE: begin
            mul_a = {1'b0, m_ff};
            mul_b = {1'b0, u_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_prod = 65'(mul_a) * 65'(mul_b);

   // divider step: one quotient bit per cycle
   assign dsr      = (state_ff == cflts_pkg::ST_RATIO) ? m_ff : runmax_ff;
   assign trial    = {rem_ff, dvd_ff[32]};
   assign ge       = trial >= {1'b0, dsr};
   assign rem_step = ge ? 32'(trial - {1'b0, dsr}) : trial[31:0];

   // truncated Q2.30 power step, sticky cap once above 2^32
   assign pow_next = mul_prod[64:30];
   assign ovf_next = ovf_ff || (pow_next > 35'h1_0000_0000);
   assign pow_val  = ovf_next ? 35'h1_0000_0001 : pow_next;
   assign u_next   = (!ovf_next && (pow_next <= sum_ff)) ? base_ff : u_ff;

   // axis combine helpers
   always_comb begin
      x_max = x_ff[0];
      if (x_ff[1] > x_max) x_max = x_ff[1];
      if (x_ff[2] > x_max) x_max = x_ff[2];
      add01  = {1'b0, x_ff[0]} + {1'b0, x_ff[1]};
      sat01  = add01[32] ? '1 : add01[31:0];
      add012 = {1'b0, sat01} + {1'b0, x_ff[2]};
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      s_in        = s_ff;
      x_in        = x_ff;
      last_in     = last_ff;
      m_in        = m_ff;
      cell_in     = cell_ff;
      runmax_in   = runmax_ff;
      acc_in      = acc_ff;
      base_in     = base_ff;
      ovf_in      = ovf_ff;
      pcnt_in     = pcnt_ff;
      sum_in      = sum_ff;
      u_in        = u_ff;
      bit_in      = bit_ff;
      root_in     = root_ff;
      rem_in      = rem_ff;
      dvd_in      = dvd_ff;
      quo_in      = quo_ff;
      dcnt_in     = dcnt_ff;
      res_time_in = res_time_ff;
      res_err_in  = res_err_ff;
      rsp_time_in = rsp_time_ff;
      rsp_err_in  = rsp_err_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;

      unique case (state_ff)
         cflts_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               for (int i = 0; i < 3; i++) begin
                  s_in[i] = {1'b0, mag[i]} + {1'b0, req_tdata[127:96]};
               end
               last_in  = req_tlast;
               cnt_in   = 2'd0;
               state_in = cflts_pkg::ST_AXIS;
            end
         end
         cflts_pkg::ST_AXIS: begin
            // (|v|+a)*inv >> 16, saturated; zero inverse spacing drops the axis
            if (inv_sel == '0) begin
               x_in[cnt_ff] = '0;
            end else if (mul_prod[64:48] != '0) begin
               x_in[cnt_ff] = '1;
            end else begin
               x_in[cnt_ff] = mul_prod[47:16];
            end
            if (cnt_ff == 2'd2) begin
               state_in = cflts_pkg::ST_COMB;
            end else begin
               cnt_in = cnt_ff + 2'd1;
            end
         end
         cflts_pkg::ST_COMB: begin
            if (mode_ff[cflts_pkg::MODE_BIT_NORM]) begin
               m_in   = x_max;
               cnt_in = 2'd0;
               sum_in = '0;
               if (x_max == '0) begin
                  cell_in  = '0;
                  state_in = cflts_pkg::ST_UPDATE;
               end else begin
                  state_in = cflts_pkg::ST_RINIT;
               end
            end else if (mode_ff[cflts_pkg::MODE_BIT_SUM]) begin
               cell_in  = add012[32] ? '1 : add012[31:0];
               state_in = cflts_pkg::ST_UPDATE;
            end else begin
               cell_in  = x_max;
               state_in = cflts_pkg::ST_UPDATE;
            end
         end
         cflts_pkg::ST_RINIT: begin
            // x <= m, so the integer bit is one only when x equals m
            if (x_ff[cnt_ff] >= m_ff) begin
               rem_in = x_ff[cnt_ff] - m_ff;
               quo_in = 33'd1;
            end else begin
               rem_in = x_ff[cnt_ff];
               quo_in = '0;
            end
            dvd_in   = '0;
            dcnt_in  = 6'(cflts_pkg::Q30_FRAC);
            state_in = cflts_pkg::ST_RATIO;
         end
         cflts_pkg::ST_RATIO: begin
            rem_in  = rem_step;
            dvd_in  = {dvd_ff[31:0], 1'b0};
            quo_in  = {quo_ff[31:0], ge};
            dcnt_in = dcnt_ff - 6'd1;
            if (dcnt_ff == 6'd1) begin
               acc_in   = {2'b0, quo_ff[29:0], ge};
               base_in  = {quo_ff[29:0], ge};
               ovf_in   = 1'b0;
               pcnt_in  = 4'd1;
               root_in  = 1'b0;
               state_in = cflts_pkg::ST_POW;
            end
         end
         cflts_pkg::ST_POW: begin
            acc_in = pow_next[32:0];
            ovf_in = ovf_next;
            if (pcnt_ff == pwr - 4'd1) begin
               pcnt_in = 4'd1;
               if (!root_ff) begin
                  sum_in = sum_ff + pow_val;
                  if (cnt_ff == 2'd2) begin
                     // start root search at the top bit
                     root_in = 1'b1;
                     u_in    = '0;
                     bit_in  = 5'(cflts_pkg::Q30_FRAC);
                     base_in = 31'd1 << cflts_pkg::Q30_FRAC;
                     acc_in  = 33'd1 << cflts_pkg::Q30_FRAC;
                     ovf_in  = 1'b0;
                  end else begin
                     cnt_in   = cnt_ff + 2'd1;
                     state_in = cflts_pkg::ST_RINIT;
                  end
               end else begin
                  u_in = u_next;
                  if (bit_ff == '0) begin
                     state_in = cflts_pkg::ST_SCALE;
                  end else begin
                     bit_in  = bit_ff - 5'd1;
                     base_in = u_next | (31'd1 << (bit_ff - 5'd1));
                     acc_in  = {2'b0, u_next | (31'd1 << (bit_ff - 5'd1))};
                     ovf_in  = 1'b0;
                  end
               end
            end else begin
               pcnt_in = pcnt_ff + 4'd1;
            end
         end
         cflts_pkg::ST_SCALE: begin
            cell_in  = (mul_prod[64:62] != '0) ? '1 : mul_prod[61:30];
            state_in = cflts_pkg::ST_UPDATE;
         end
         cflts_pkg::ST_UPDATE: begin
            if (cell_ff > runmax_ff) runmax_in = cell_ff;
            state_in = last_ff ? cflts_pkg::ST_FINISH : cflts_pkg::ST_IDLE;
         end
         cflts_pkg::ST_FINISH: begin
            if (runmax_ff == '0) begin
               res_time_in = '0;
               res_err_in  = 1'b1;
               state_in    = cflts_pkg::ST_OUT;
            end else begin
               rem_in   = '0;
               dvd_in   = {coeff_ff, 16'd0};
               quo_in   = '0;
               dcnt_in  = 6'd33;
               state_in = cflts_pkg::ST_DIV;
            end
         end
         cflts_pkg::ST_DIV: begin
            rem_in  = rem_step;
            dvd_in  = {dvd_ff[31:0], 1'b0};
            quo_in  = {quo_ff[31:0], ge};
            dcnt_in = dcnt_ff - 6'd1;
            if (dcnt_ff == 6'd1) begin
               res_time_in = quo_ff[31] ? '1 : {quo_ff[30:0], ge};
               res_err_in  = 1'b0;
               state_in    = cflts_pkg::ST_OUT;
            end
         end
         cflts_pkg::ST_OUT: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_time_in   = res_time_ff;
               rsp_err_in    = res_err_ff;
               rsp_tvalid_in = 1'b1;
               runmax_in     = '0;
               state_in      = cflts_pkg::ST_IDLE;
            end
         end
         default: state_in = cflts_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cflts_pkg::ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         runmax_ff     <= '0;
         inv_x_ff      <= 32'd65536;
         inv_y_ff      <= '0;
         inv_z_ff      <= '0;
         mode_ff       <= 2'd1;
         power_ff      <= 4'd2;
         coeff_ff      <= 17'd32768;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         runmax_ff     <= runmax_in;
         if (csr_valid) begin
            unique case (csr_index)
               cflts_pkg::CSR_INV_X: inv_x_ff <= csr_data;
               cflts_pkg::CSR_INV_Y: inv_y_ff <= csr_data;
               cflts_pkg::CSR_INV_Z: inv_z_ff <= csr_data;
               cflts_pkg::CSR_MODE:  mode_ff  <= csr_data[1:0];
               cflts_pkg::CSR_POWER: power_ff <= csr_data[3:0];
               cflts_pkg::CSR_COEFF: coeff_ff <= csr_data[16:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      s_ff        <= s_in;
      x_ff        <= x_in;
      last_ff     <= last_in;
      m_ff        <= m_in;
      cell_ff     <= cell_in;
      acc_ff      <= acc_in;
      base_ff     <= base_in;
      ovf_ff      <= ovf_in;
      pcnt_ff     <= pcnt_in;
      sum_ff      <= sum_in;
      u_ff        <= u_in;
      bit_ff      <= bit_in;
      root_ff     <= root_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      quo_ff      <= quo_in;
      dcnt_ff     <= dcnt_in;
      res_time_ff <= res_time_in;
      res_err_ff  <= res_err_in;
      rsp_time_ff <= rsp_time_in;
      rsp_err_ff  <= rsp_err_in;
   end

endmodule
`default_nettype wire

FILE: sv/cflts_checker.sv
// Port-level checks for the CFL timestep reduction unit, bound to the top level.
// Depends on cfl_timestep_reduction_unit ports only.
`timescale 1ns / 1ps
`default_nettype none
module cflts_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [31:0]  rsp_tdata,
   input wire logic [0:0]   rsp_tuser
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // zero-speed error carries a zero timestep
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 32'd0)
      else $error("error transaction with nonzero timestep");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // ready is low in the cycle after a cell is accepted
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after a cell transaction");

endmodule

bind cfl_timestep_reduction_unit cflts_checker u_cflts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
